/* sv/pyb2r_pkg.sv */
`timescale 1ns / 1ps

package pyb2r_pkg;

    localparam int PIXELS_PER_BLOCK = 64;
    localparam int BYTES_PER_BLOCK  = 3 * PIXELS_PER_BLOCK;
    localparam int POS_W            = $clog2(BYTES_PER_BLOCK);
    localparam int IDX_W            = (PIXELS_PER_BLOCK > 1) ? $clog2(PIXELS_PER_BLOCK) : 1;

    localparam int DATA_W    = 8;
    localparam int PIX_IDX_W = 6;
    localparam int COUNT_W   = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [DATA_W-1:0]    luma;
        logic [DATA_W-1:0]    chroma_u;
        logic [DATA_W-1:0]    chroma_v;
        logic [PIX_IDX_W-1:0] pixel_index;
        logic                 block_end;
        logic                 run_end;
    } t_task;

    typedef struct packed {
        logic [Q_CNT_W-1:0] level;
    } t_q_stat;

endpackage

/* sv/pyb2r_byte_if.sv */
`timescale 1ns / 1ps

interface pyb2r_byte_if import pyb2r_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* sv/pyb2r_pix_if.sv */
`timescale 1ns / 1ps

interface pyb2r_pix_if import pyb2r_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    red;
    logic [DATA_W-1:0]    green;
    logic [DATA_W-1:0]    blue;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic                 block_end;
    logic                 run_end;

    modport source (output valid, output red, output green, output blue,
                    output pixel_index, output block_end, output run_end,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input pixel_index, input block_end, input run_end,
                    output ready);
endinterface

/* sv/pyb2r_ram.sv */
`timescale 1ns / 1ps

module pyb2r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pyb2r_front.sv */
`timescale 1ns / 1ps

module pyb2r_front import pyb2r_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    pyb2r_byte_if.sink         i_in,
    input  t_q_stat            i_q_stat,
    output logic               o_push,
    output t_task              o_push_task
);

    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic [COUNT_W-1:0] r_blocks_done;
    logic [COUNT_W-1:0] r_block_count;
    logic               r_pend;
    logic [DATA_W-1:0]  r_pend_v;
    logic [IDX_W-1:0]   r_pend_idx;
    logic               r_pend_last;
    logic               r_pend_run;

    logic               w_accept;
    logic               w_is_y;
    logic               w_is_u;
    logic               w_is_v;
    logic [IDX_W-1:0]   w_y_addr;
    logic [IDX_W-1:0]   w_u_addr;
    logic [IDX_W-1:0]   w_v_addr;
    logic               w_last;
    logic               w_run;
    logic [COUNT_W:0]   w_done_inc;
    logic [Q_CNT_W:0]   w_fill;
    logic [DATA_W-1:0]  w_luma;
    logic [DATA_W-1:0]  w_chroma_u;

    assign w_is_y   = r_pos < POS_W'(PIXELS_PER_BLOCK);
    assign w_is_u   = !w_is_y && (r_pos < POS_W'(2 * PIXELS_PER_BLOCK));
    assign w_is_v   = !w_is_y && !w_is_u;
    assign w_y_addr = IDX_W'(r_pos);
    assign w_u_addr = IDX_W'(r_pos - POS_W'(PIXELS_PER_BLOCK));
    assign w_v_addr = IDX_W'(r_pos - POS_W'(2 * PIXELS_PER_BLOCK));
    assign w_last   = w_v_addr == IDX_W'(PIXELS_PER_BLOCK - 1);

    assign w_done_inc = {1'b0, r_blocks_done} + (COUNT_W + 1)'(1);
    assign w_run      = w_last && (w_done_inc >= {1'b0, r_block_count});

    // reserve a slot for the pending read as well
    assign w_fill     = {1'b0, i_q_stat.level} + (Q_CNT_W + 1)'(r_pend);
    assign i_in.ready = w_fill < (Q_CNT_W + 1)'(Q_DEPTH);
    assign w_accept   = i_in.valid && i_in.ready;

    assign n_pos = (r_pos == POS_W'(BYTES_PER_BLOCK - 1)) ? '0 : r_pos + POS_W'(1);

    pyb2r_ram #(.WIDTH(DATA_W), .DEPTH(PIXELS_PER_BLOCK)) u_luma_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_is_y),
        .i_waddr (w_y_addr),
        .i_wdata (i_in.data_byte),
        .i_raddr (w_v_addr),
        .o_rdata (w_luma)
    );

    pyb2r_ram #(.WIDTH(DATA_W), .DEPTH(PIXELS_PER_BLOCK)) u_chroma_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_is_u),
        .i_waddr (w_u_addr),
        .i_wdata (i_in.data_byte),
        .i_raddr (w_v_addr),
        .o_rdata (w_chroma_u)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_blocks_done <= '0;
            r_block_count <= COUNT_W'(1);
            r_pend        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_count <= i_cfg_wdata;
            end
            r_pend <= w_accept && w_is_v;
            if (w_accept) begin
                r_pos <= n_pos;
                if (w_is_v && w_last) begin
                    r_blocks_done <= w_run ? '0 : w_done_inc[COUNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_v) begin
            r_pend_v    <= i_in.data_byte;
            r_pend_idx  <= w_v_addr;
            r_pend_last <= w_last;
            r_pend_run  <= w_run;
        end
    end

    assign o_push                  = r_pend;
    assign o_push_task.luma        = w_luma;
    assign o_push_task.chroma_u    = w_chroma_u;
    assign o_push_task.chroma_v    = r_pend_v;
    assign o_push_task.pixel_index = PIX_IDX_W'(r_pend_idx);
    assign o_push_task.block_end   = r_pend_last;
    assign o_push_task.run_end     = r_pend_run;

endmodule

/* sv/pyb2r_queue.sv */
`timescale 1ns / 1ps

module pyb2r_queue import pyb2r_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_task   i_push_task,
    input  logic    i_pop,
    output logic    o_valid,
    output t_task   o_task,
    output t_q_stat o_stat
);

    t_task              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_pop;

    assign o_valid = r_cnt != '0;
    assign o_task  = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;
    assign o_stat.level = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_task;
        end
    end

endmodule

/* sv/pyb2r_back.sv */
`timescale 1ns / 1ps

module pyb2r_back import pyb2r_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_task        i_task,
    output logic         o_pop,
    pyb2r_pix_if.source  o_out
);

    localparam int PROD_W = 28;
    localparam int FRAC_W = 16;
    localparam int INT_W  = PROD_W - FRAC_W;

    localparam logic signed [PROD_W-1:0] K_Y  = 28'sd76284;
    localparam logic signed [PROD_W-1:0] K_RV = 28'sd104595;
    localparam logic signed [PROD_W-1:0] K_GV = 28'sd53281;
    localparam logic signed [PROD_W-1:0] K_GU = 28'sd25625;
    localparam logic signed [PROD_W-1:0] K_BU = 28'sd132252;

    function automatic logic [DATA_W-1:0] shift_sat(input logic signed [PROD_W-1:0] x);
        logic signed [INT_W-1:0] q;
        q = x[PROD_W-1:FRAC_W];
        if (q < 0) begin
            shift_sat = '0;
        end else if (q > 255) begin
            shift_sat = '1;
        end else begin
            shift_sat = q[DATA_W-1:0];
        end
    endfunction

    logic signed [DATA_W:0]   w_y;
    logic signed [DATA_W:0]   w_u;
    logic signed [DATA_W:0]   w_v;
    logic signed [PROD_W-1:0] w_y_ext;
    logic signed [PROD_W-1:0] w_u_ext;
    logic signed [PROD_W-1:0] w_v_ext;
    logic signed [PROD_W-1:0] w_sum_r;
    logic signed [PROD_W-1:0] w_sum_g;
    logic signed [PROD_W-1:0] w_sum_b;
    logic                     w_out_adv;
    logic                     w_s1_adv;

    logic                     r_s1_vld;
    logic signed [PROD_W-1:0] r_s1_y;
    logic signed [PROD_W-1:0] r_s1_rv;
    logic signed [PROD_W-1:0] r_s1_gv;
    logic signed [PROD_W-1:0] r_s1_gu;
    logic signed [PROD_W-1:0] r_s1_bu;
    logic [PIX_IDX_W-1:0]     r_s1_idx;
    logic                     r_s1_last;
    logic                     r_s1_run;

    logic                     r_out_vld;
    logic [DATA_W-1:0]        r_red;
    logic [DATA_W-1:0]        r_green;
    logic [DATA_W-1:0]        r_blue;
    logic [PIX_IDX_W-1:0]     r_idx;
    logic                     r_last;
    logic                     r_run;

    assign w_y = $signed({1'b0, i_task.luma})     - 9'sd16;
    assign w_u = $signed({1'b0, i_task.chroma_u}) - 9'sd128;
    assign w_v = $signed({1'b0, i_task.chroma_v}) - 9'sd128;

    assign w_y_ext = PROD_W'(w_y);
    assign w_u_ext = PROD_W'(w_u);
    assign w_v_ext = PROD_W'(w_v);

    assign w_sum_r = r_s1_y + r_s1_rv;
    assign w_sum_g = r_s1_y - r_s1_gv - r_s1_gu;
    assign w_sum_b = r_s1_y + r_s1_bu;

    assign w_out_adv = !r_out_vld || o_out.ready;
    assign w_s1_adv  = !r_s1_vld || w_out_adv;
    assign o_pop     = i_valid && w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_vld <= i_valid;
            end
            if (w_out_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_y    <= w_y_ext * K_Y;
            r_s1_rv   <= w_v_ext * K_RV;
            r_s1_gv   <= w_v_ext * K_GV;
            r_s1_gu   <= w_u_ext * K_GU;
            r_s1_bu   <= w_u_ext * K_BU;
            r_s1_idx  <= i_task.pixel_index;
            r_s1_last <= i_task.block_end;
            r_s1_run  <= i_task.run_end;
        end
        if (w_out_adv && r_s1_vld) begin
            r_red   <= shift_sat(w_sum_r);
            r_green <= shift_sat(w_sum_g);
            r_blue  <= shift_sat(w_sum_b);
            r_idx   <= r_s1_idx;
            r_last  <= r_s1_last;
            r_run   <= r_s1_run;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.red         = r_red;
    assign o_out.green       = r_green;
    assign o_out.blue        = r_blue;
    assign o_out.pixel_index = r_idx;
    assign o_out.block_end   = r_last;
    assign o_out.run_end     = r_run;

endmodule

/* sv/planar_yuv_block_to_rgb_core.sv */
`timescale 1ns / 1ps
// Path: a pixel's V byte passes the pending register, task queue, stage-1 and output registers.
// Throughput: one byte per cycle while the queue has room; one pixel per three bytes, set
// by the Y/U plane RAM read port, the task queue and the two-stage multiply / saturate pipeline.
// Reset: synchronous, active low; clears byte position, block counter, queue and
// pipeline, and sets the block count to 1. The plane RAMs are not cleared.

module planar_yuv_block_to_rgb_core import pyb2r_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    pyb2r_byte_if.sink         i_in,
    pyb2r_pix_if.source        o_out
);

    logic    w_push;
    t_task   w_push_task;
    logic    w_q_valid;
    t_task   w_q_task;
    t_q_stat w_q_stat;
    logic    w_pop;

    pyb2r_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_task (w_push_task)
    );

    pyb2r_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_task (w_push_task),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_task      (w_q_task),
        .o_stat      (w_q_stat)
    );

    pyb2r_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_task  (w_q_task),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
